### design/euler_to_quaternion_top_defines.svh
// Assertion macros for the euler_to_quaternion design files; only e2q_queue includes them.
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define E2Q_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define E2Q_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/e2q_pkg.sv
// Shared types, constants and helper functions of the Euler angle to quaternion converter.
package e2q_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int ANG_W           = 16;
   localparam int OUT_W           = 16;
   localparam int TURN_W          = 32;
   localparam int CW              = 34;
   localparam int LANES           = 3;
   localparam int CORDIC_STEPS    = 30;
   localparam int QDepth          = 4;

   // 720 degrees = 45 * 16, so the half-angle divisor is 45 * 2^(ANGLE_FRAC_BITS + 4).
   localparam int TurnShift  = 28 - ANGLE_FRAC_BITS;
   localparam longint TurnDiv  = 45;
   localparam longint TurnHalf = TurnDiv / 2;
   localparam int RecipShift = 21;
   localparam longint Recip  = ((longint'(1) << RecipShift) + TurnDiv - 1) / TurnDiv;

   localparam int RoundShift = 30 - OUT_FRAC_BITS;
   localparam longint RoundHalf = (RoundShift > 0) ? (longint'(1) << (RoundShift - 1)) : 0;
   localparam longint OutLim    = longint'(1) << OUT_FRAC_BITS;

   localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
   localparam logic signed [CW-1:0] QuarterTurn = 34'sd1073741824;
   localparam logic signed [CW-1:0] HalfTurn    = 34'sd2147483648;

   localparam logic [TURN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef logic [LANES-1:0][TURN_W-1:0] lane_turns_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

   // Binary-angle share of the remainder left after dividing the magnitude by 45.
   function automatic logic [TURN_W-1:0] frac_turn(input logic [5:0] rem);
      longint v;
      v = ((longint'(rem) << TurnShift) + TurnHalf) / TurnDiv;
      return v[TURN_W-1:0];
   endfunction

   // Round a Q4.60 product back to Q2.30.
   function automatic logic signed [31:0] mul_round(input logic signed [63:0] p);
      logic signed [63:0] r;
      r = (p + 64'sd536870912) >>> 30;
      return r[31:0];
   endfunction

   // Round a Q3.30 sum of two Q2.30 products to the output format and clamp it to plus or minus one.
   function automatic logic [OUT_W-1:0] finish(input logic signed [32:0] v);
      logic signed [33:0] r;
      r = (34'(v) + 34'(RoundHalf)) >>> RoundShift;
      if (r > 34'(OutLim)) begin
         r = 34'(OutLim);
      end else if (r < -34'(OutLim)) begin
         r = -34'(OutLim);
      end
      return r[OUT_W-1:0];
   endfunction

endpackage

### design/e2q_front.sv
// Front end: accepts angle requests and turns each into a half-angle binary angle.
module e2q_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [47:0]             req_tdata,
   output logic                    q_push,
   output e2q_pkg::lane_turns_type q_wdata,
   input  e2q_pkg::q_status_type   q_status
);

   logic                          en_f;
   logic [e2q_pkg::ANG_W-1:0]     raw      [e2q_pkg::LANES];
   logic [e2q_pkg::LANES-1:0]     flip;
   logic [e2q_pkg::ANG_W-1:0]     mag_in   [e2q_pkg::LANES];
   logic [e2q_pkg::LANES-1:0]     neg_in;
   logic [31:0]                   prod_in  [e2q_pkg::LANES];
   logic                          f1_valid_ff;
   logic [e2q_pkg::ANG_W-1:0]     f1_mag_ff  [e2q_pkg::LANES];
   logic [e2q_pkg::LANES-1:0]     f1_neg_ff;
   logic [31:0]                   f1_prod_ff [e2q_pkg::LANES];
   logic                          f2_valid_ff;
   e2q_pkg::lane_turns_type       f2_turn_in;
   e2q_pkg::lane_turns_type       f2_turn_ff;

   // Lane order: y gives c1/s1, negated z gives c2/s2, x gives c3/s3.
   assign raw[0] = req_tdata[31:16];
   assign raw[1] = req_tdata[47:32];
   assign raw[2] = req_tdata[15:0];
   assign flip   = 3'b010;

   assign en_f       = !f2_valid_ff || !q_status.full;
   assign req_tready = en_f;
   assign q_push     = f2_valid_ff && !q_status.full;
   assign q_wdata    = f2_turn_ff;

   always_comb begin
      for (int l = 0; l < e2q_pkg::LANES; l++) begin
         mag_in[l]  = raw[l][e2q_pkg::ANG_W-1] ? (16'd0 - raw[l]) : raw[l];
         neg_in[l]  = raw[l][e2q_pkg::ANG_W-1] ^ flip[l];
         prod_in[l] = 32'(mag_in[l]) * 32'(e2q_pkg::Recip);
      end
   end

   // Magnitude = 45*quot + rem; quot by reciprocal multiply, rem through a small table.
   always_comb begin
      logic [10:0]              quot;
      logic [16:0]              quot45;
      logic [5:0]               rem;
      logic [e2q_pkg::TURN_W-1:0] t;
      for (int l = 0; l < e2q_pkg::LANES; l++) begin
         quot   = f1_prod_ff[l][31:e2q_pkg::RecipShift];
         quot45 = 17'(quot) * 17'(e2q_pkg::TurnDiv);
         rem    = 6'(17'(f1_mag_ff[l]) - quot45);
         t      = (32'(quot) << e2q_pkg::TurnShift) + e2q_pkg::frac_turn(rem);
         f2_turn_in[l] = f1_neg_ff[l] ? (32'd0 - t) : t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en_f) begin
         f1_valid_ff <= req_tvalid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         for (int l = 0; l < e2q_pkg::LANES; l++) begin
            f1_mag_ff[l]  <= mag_in[l];
            f1_prod_ff[l] <= prod_in[l];
         end
         f1_neg_ff  <= neg_in;
         f2_turn_ff <= f2_turn_in;
      end
   end

endmodule

### design/e2q_queue.sv
// Short queue of half-angle triples between the front end and the CORDIC back end.
`include "euler_to_quaternion_top_defines.svh"
module e2q_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_push,
   input  e2q_pkg::lane_turns_type q_wdata,
   input  logic                    q_pop,
   output e2q_pkg::lane_turns_type q_rdata,
   output e2q_pkg::q_status_type   q_status
);

   localparam int PtrW = $clog2(e2q_pkg::QDepth);
   localparam int CntW = $clog2(e2q_pkg::QDepth + 1);

   e2q_pkg::lane_turns_type mem_ff [e2q_pkg::QDepth];
   logic [PtrW-1:0]         wr_ptr_ff;
   logic [PtrW-1:0]         rd_ptr_ff;
   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;

   assign q_rdata        = mem_ff[rd_ptr_ff];
   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == CntW'(e2q_pkg::QDepth));

   always_comb begin
      count_in = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   `E2Q_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(e2q_pkg::QDepth), "queue count beyond depth")
   `E2Q_ASSERT_NOW(a_no_overflow, clock, reset, q_push, !q_status.full, "push into a full queue")
   `E2Q_ASSERT_NOW(a_no_underflow, clock, reset, q_pop, q_status.valid, "pop from an empty queue")
   `E2Q_ASSERT_NEXT(a_count_up, clock, reset, q_push && !q_pop, count_ff == $past(count_ff) + 1'b1, "count did not grow on push")

endmodule

### design/e2q_back.sv
// Back end: pipelined CORDIC sine/cosine for three lanes and the quaternion products.
module e2q_back (
   input  logic                    clock,
   input  logic                    reset,
   input  e2q_pkg::q_status_type   q_status,
   input  e2q_pkg::lane_turns_type q_rdata,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata
);

   localparam int NS = e2q_pkg::CORDIC_STEPS;
   localparam int CW = e2q_pkg::CW;
   localparam int L  = e2q_pkg::LANES;

   logic                 en_b;
   logic [NS:0]          cv_ff;
   logic signed [CW-1:0] cx_ff [NS+1][L];
   logic signed [CW-1:0] cy_ff [NS+1][L];
   logic signed [CW-1:0] cz_ff [NS+1][L];
   logic [L-1:0]         cn_ff [NS+1];
   logic signed [CW-1:0] cx_in [NS+1][L];
   logic signed [CW-1:0] cy_in [NS+1][L];
   logic signed [CW-1:0] cz_in [NS+1][L];
   logic [L-1:0]         cn_in;

   logic                 vs_ff;
   logic signed [31:0]   c_ff [L];
   logic signed [31:0]   s_ff [L];

   logic                 vp1_ff;
   logic signed [31:0]   c1c2_ff, s1s2_ff, s1c2_ff, c1s2_ff, c3_ff, s3_ff;
   logic                 vp2_ff;
   logic signed [31:0]   pr_ff [8];

   logic                 rsp_tvalid_ff;
   logic [63:0]          rsp_tdata_ff;
   logic [63:0]          rsp_tdata_in;

   // The whole pipeline advances unless the output register holds an untaken response.
   assign en_b       = !rsp_tvalid_ff || rsp_tready;
   assign q_pop      = q_status.valid && en_b;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Entry folds the angle into plus or minus a quarter turn, remembering a sign flip;
   // then one CORDIC rotation per stage.
   always_comb begin
      logic signed [CW-1:0] z;
      logic signed [CW-1:0] at;
      for (int l = 0; l < L; l++) begin
         z        = CW'($signed(q_rdata[l]));
         cn_in[l] = 1'b0;
         if (z > e2q_pkg::QuarterTurn) begin
            z        = z - e2q_pkg::HalfTurn;
            cn_in[l] = 1'b1;
         end else if (z < -e2q_pkg::QuarterTurn) begin
            z        = z + e2q_pkg::HalfTurn;
            cn_in[l] = 1'b1;
         end
         cx_in[0][l] = e2q_pkg::CordicGain;
         cy_in[0][l] = '0;
         cz_in[0][l] = z;
      end
      for (int i = 0; i < NS; i++) begin
         at = CW'(e2q_pkg::ATAN_TAB[i]);
         for (int l = 0; l < L; l++) begin
            if (!cz_ff[i][l][CW-1]) begin
               cx_in[i+1][l] = cx_ff[i][l] - (cy_ff[i][l] >>> i);
               cy_in[i+1][l] = cy_ff[i][l] + (cx_ff[i][l] >>> i);
               cz_in[i+1][l] = cz_ff[i][l] - at;
            end else begin
               cx_in[i+1][l] = cx_ff[i][l] + (cy_ff[i][l] >>> i);
               cy_in[i+1][l] = cy_ff[i][l] - (cx_ff[i][l] >>> i);
               cz_in[i+1][l] = cz_ff[i][l] + at;
            end
         end
      end
   end

   always_comb begin
      logic signed [32:0] sw, sx, sy, sz;
      sw = 33'(pr_ff[0]) - 33'(pr_ff[1]);
      sx = 33'(pr_ff[2]) + 33'(pr_ff[3]);
      sy = 33'(pr_ff[4]) + 33'(pr_ff[5]);
      sz = 33'(pr_ff[6]) - 33'(pr_ff[7]);
      rsp_tdata_in = {e2q_pkg::finish(sz), e2q_pkg::finish(sy),
                      e2q_pkg::finish(sx), e2q_pkg::finish(sw)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff         <= '0;
         vs_ff         <= 1'b0;
         vp1_ff        <= 1'b0;
         vp2_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en_b) begin
         cv_ff         <= {cv_ff[NS-1:0], q_status.valid};
         vs_ff         <= cv_ff[NS];
         vp1_ff        <= vs_ff;
         vp2_ff        <= vp1_ff;
         rsp_tvalid_ff <= vp2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         cn_ff[0] <= cn_in;
         for (int i = 0; i <= NS; i++) begin
            if (i > 0) begin
               cn_ff[i] <= cn_ff[i-1];
            end
            for (int l = 0; l < L; l++) begin
               cx_ff[i][l] <= cx_in[i][l];
               cy_ff[i][l] <= cy_in[i][l];
               cz_ff[i][l] <= cz_in[i][l];
            end
         end
         for (int l = 0; l < L; l++) begin
            c_ff[l] <= cn_ff[NS][l] ? 32'(-cx_ff[NS][l]) : 32'(cx_ff[NS][l]);
            s_ff[l] <= cn_ff[NS][l] ? 32'(-cy_ff[NS][l]) : 32'(cy_ff[NS][l]);
         end
         c1c2_ff <= e2q_pkg::mul_round(64'(c_ff[0]) * 64'(c_ff[1]));
         s1s2_ff <= e2q_pkg::mul_round(64'(s_ff[0]) * 64'(s_ff[1]));
         s1c2_ff <= e2q_pkg::mul_round(64'(s_ff[0]) * 64'(c_ff[1]));
         c1s2_ff <= e2q_pkg::mul_round(64'(c_ff[0]) * 64'(s_ff[1]));
         c3_ff   <= c_ff[2];
         s3_ff   <= s_ff[2];
         pr_ff[0] <= e2q_pkg::mul_round(64'(c1c2_ff) * 64'(c3_ff));
         pr_ff[1] <= e2q_pkg::mul_round(64'(s1s2_ff) * 64'(s3_ff));
         pr_ff[2] <= e2q_pkg::mul_round(64'(c1c2_ff) * 64'(s3_ff));
         pr_ff[3] <= e2q_pkg::mul_round(64'(s1s2_ff) * 64'(c3_ff));
         pr_ff[4] <= e2q_pkg::mul_round(64'(s1c2_ff) * 64'(c3_ff));
         pr_ff[5] <= e2q_pkg::mul_round(64'(c1s2_ff) * 64'(s3_ff));
         pr_ff[6] <= e2q_pkg::mul_round(64'(c1s2_ff) * 64'(c3_ff));
         pr_ff[7] <= e2q_pkg::mul_round(64'(s1c2_ff) * 64'(s3_ff));
         if (vp2_ff) begin
            rsp_tdata_ff <= rsp_tdata_in;
         end
      end
   end

endmodule

### design/euler_to_quaternion_top.sv
// Path to rsp_tvalid: f1, f2, queue, CORDIC entry, rotations, sine/cosine, products, output.
// Throughput: one request per cycle unless the output stalls; 30-stage CORDIC is fully pipelined.
// The front end keeps taking requests while the back end stalls, until the
// four-entry queue between them fills.
// Reset (synchronous, active high) empties every stage and the queue; no state outlives a request.
module euler_to_quaternion_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // angle_x_deg, angle_y_deg, angle_z_deg (low to high)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // quat_w, quat_x, quat_y, quat_z (low to high)
);

   // Half-angle binary angles handed from the front end to the back end.
   e2q_pkg::lane_turns_type q_wdata;
   e2q_pkg::lane_turns_type q_rdata;
   e2q_pkg::q_status_type   q_status;
   logic                    q_push;
   logic                    q_pop;

   // The front end halves each angle, converts degrees to a binary angle by a
   // reciprocal multiply and a remainder table, and pushes the triple.
   e2q_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_wdata    (q_wdata),
      .q_status   (q_status)
   );

   // The queue lets the front end keep accepting requests while the back end waits.
   e2q_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_wdata  (q_wdata),
      .q_pop    (q_pop),
      .q_rdata  (q_rdata),
      .q_status (q_status)
   );

   // The back end forms sines and cosines, combines them into the quaternion,
   // rounds, clamps to plus or minus one and holds the result in an output register.
   e2q_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
